FILE: hw/rtl/xor_checked_packet_deframer_core_defines.svh
// assertion macros shared by the deframer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef XOR_CHECKED_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define XOR_CHECKED_PACKET_DEFRAMER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define XCPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define XCPD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XCPD_ASSERT(lbl, prop, msg)
`define XCPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/xcpd_pkg.sv
// shared types, codes and constants for the packet deframer
// no dependencies
package xcpd_pkg;

	localparam logic [7:0]  SOP_BYTE      = 8'h1B;
	localparam logic [7:0]  EOP_BYTE      = 8'h0A;
	localparam logic [7:0]  TYPE_SIG      = 8'h53;
	localparam logic [15:0] TIMEOUT_RESET = 16'd500;
	localparam logic [7:0]  HEADER_RESET  = 8'd30;
	localparam logic [15:0] MAXDATA_RESET = 16'd4096;

	typedef enum logic [1:0] {
		REG_TIMEOUT  = 2'd0,
		REG_HEADER   = 2'd1,
		REG_MAX_DATA = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		EV_NONE    = 4'd0,
		EV_HDR     = 4'd1,
		EV_DATA    = 4'd2,
		EV_GOOD    = 4'd3,
		EV_BADTYPE = 4'd4,
		EV_SHORT   = 4'd5,
		EV_CKSUM   = 4'd6,
		EV_NOEOP   = 4'd7,
		EV_OVF     = 4'd8,
		EV_TIMEOUT = 4'd9
	} event_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [7:0]  header_bytes;
		logic [15:0] max_data_bytes;
	} cfg_t;

	typedef struct packed {
		event_t      event_res;
		logic [7:0]  out_byte;
		logic [15:0] byte_index;
		logic [15:0] data_length;
		logic [31:0] frames_good;
	} res_t;

endpackage

FILE: hw/rtl/xor_checked_packet_deframer_core.sv
// channel  | valid/ready                  | payload
// input    | s_axis_tvalid/s_axis_tready  | tdata: rx_byte, tuser: op
// output   | m_axis_tvalid/m_axis_tready  | tdata: out_byte..frames_good, tuser: event_res
// config   | cfg_we (no ready)            | cfg_index, cfg_data
//
// one beat per cycle sustained while the output is ready; a beat passes from input to output
// through the input register, then the step logic into a two-entry result buffer
// arst_n clears the frame state, counters, buffers and restores register defaults
// output stalls back up through the result buffer into the input register
// depends on xcpd_pkg, xcpd_regs, xcpd_fsm, xcpd_outq
module xor_checked_packet_deframer_core
	import xcpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_axis_tuser,   // [0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [7:0] out_byte, [23:8] byte_index,
	                                    // [39:24] data_length, [71:40] frames_good
	output logic [3:0]  m_axis_tuser,   // [3:0] event_res
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t       cfg;
	res_t       step_res;
	res_t       out_res;
	logic       vld_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       full;
	logic       step;
	logic       in_beat;

	assign step          = vld_s1 && !full;
	assign s_axis_tready = !vld_s1 || step;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_s1   <= s_axis_tuser[0];
			byte_s1 <= s_axis_tdata;
		end
	end

	xcpd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	xcpd_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.op      (op_s1),
		.rx_byte (byte_s1),
		.res     (step_res)
	);

	xcpd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_res  (step_res),
		.full      (full),
		.pop_valid (m_axis_tvalid),
		.pop_ready (m_axis_tready),
		.pop_res   (out_res)
	);

	assign m_axis_tuser = out_res.event_res;
	assign m_axis_tdata = {out_res.frames_good, out_res.data_length,
	                       out_res.byte_index, out_res.out_byte};

endmodule

FILE: hw/rtl/xcpd_regs.sv
// configuration registers of the deframer
// depends on xcpd_pkg
module xcpd_regs
	import xcpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks  <= TIMEOUT_RESET;
			cfg_q.header_bytes   <= HEADER_RESET;
			cfg_q.max_data_bytes <= MAXDATA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT:  cfg_q.timeout_ticks  <= cfg_data;
				REG_HEADER:   cfg_q.header_bytes   <= cfg_data[7:0];
				REG_MAX_DATA: cfg_q.max_data_bytes <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/xcpd_fsm.sv
// frame parsing state machine: one byte or tick per step
// depends on xcpd_pkg and the assertion macro header
`include "xor_checked_packet_deframer_core_defines.svh"
module xcpd_fsm
	import xcpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic       op,
	input  logic [7:0] rx_byte,
	output res_t       res
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_TYPE, PH_LEN, PH_HDR, PH_DATA, PH_CHECK, PH_END, PH_DISCARD
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  check_q, check_d;
	logic [15:0] plen_q, plen_d;
	logic [15:0] bcnt_q, bcnt_d;
	logic [15:0] siglen_q, siglen_d;
	logic [15:0] ticks_q, ticks_d;
	logic [31:0] good_q, good_d;

	logic [16:0] bcnt_inc;
	logic [15:0] hdr_len;
	logic [15:0] tick_inc;
	logic [15:0] plen_new;
	event_t      ev;
	logic [7:0]  ob;
	logic [15:0] idx;

	assign bcnt_inc = {1'b0, bcnt_q} + 17'd1;
	// a zero header length counts as one byte
	assign hdr_len  = {8'd0, (cfg.header_bytes == 8'd0) ? 8'd1 : cfg.header_bytes};
	assign tick_inc = (&ticks_q) ? ticks_q : ticks_q + 16'd1;
	assign plen_new = {plen_q[7:0], rx_byte};

	always_comb begin
		phase_d  = phase_q;
		check_d  = check_q;
		plen_d   = plen_q;
		bcnt_d   = bcnt_q;
		siglen_d = siglen_q;
		ticks_d  = ticks_q;
		good_d   = good_q;
		ev       = EV_NONE;
		ob       = 8'd0;
		idx      = 16'd0;
		if (op) begin
			if (phase_q != PH_IDLE) begin
				ticks_d = tick_inc;
				if (tick_inc >= cfg.timeout_ticks) begin
					ev      = EV_TIMEOUT;
					phase_d = PH_IDLE;
				end
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (rx_byte == SOP_BYTE) begin
						check_d = 8'd0;
						ticks_d = 16'd0;
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					check_d = check_q ^ rx_byte;
					plen_d  = 16'd0;
					bcnt_d  = 16'd0;
					if (rx_byte == TYPE_SIG) begin
						phase_d = PH_LEN;
					end else begin
						ev      = EV_BADTYPE;
						phase_d = PH_IDLE;
					end
				end
				PH_LEN: begin
					check_d = check_q ^ rx_byte;
					plen_d  = plen_new;
					bcnt_d  = bcnt_inc[15:0];
					if (bcnt_inc >= 17'd2) begin
						if (plen_new > {8'd0, cfg.header_bytes}) begin
							siglen_d = plen_new - {8'd0, cfg.header_bytes} - 16'd1;
							bcnt_d   = 16'd0;
							phase_d  = PH_HDR;
						end else begin
							ev      = EV_SHORT;
							phase_d = PH_IDLE;
						end
					end
				end
				PH_HDR: begin
					check_d = check_q ^ rx_byte;
					ev      = EV_HDR;
					ob      = rx_byte;
					idx     = bcnt_q;
					bcnt_d  = bcnt_inc[15:0];
					if (bcnt_inc >= {1'b0, hdr_len}) begin
						bcnt_d  = 16'd0;
						phase_d = (siglen_q == 16'd0) ? PH_CHECK : PH_DATA;
					end
				end
				PH_DATA: begin
					if (bcnt_q >= cfg.max_data_bytes) begin
						ev      = EV_OVF;
						phase_d = PH_DISCARD;
					end else begin
						check_d = check_q ^ rx_byte;
						ev      = EV_DATA;
						ob      = rx_byte;
						idx     = bcnt_q;
						bcnt_d  = bcnt_inc[15:0];
						if (bcnt_inc >= {1'b0, siglen_q})
							phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (check_q == rx_byte) begin
						phase_d = PH_END;
					end else begin
						ev      = EV_CKSUM;
						phase_d = PH_IDLE;
					end
				end
				PH_END: begin
					if (rx_byte == EOP_BYTE) begin
						good_d = good_q + 32'd1;
						ev     = EV_GOOD;
					end else begin
						ev = EV_NOEOP;
					end
					phase_d = PH_IDLE;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			check_q  <= 8'd0;
			plen_q   <= 16'd0;
			bcnt_q   <= 16'd0;
			siglen_q <= 16'd0;
			ticks_q  <= 16'd0;
			good_q   <= 32'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			check_q  <= check_d;
			plen_q   <= plen_d;
			bcnt_q   <= bcnt_d;
			siglen_q <= siglen_d;
			ticks_q  <= ticks_d;
			good_q   <= good_d;
		end
	end

	assign res.event_res   = ev;
	assign res.out_byte    = ob;
	assign res.byte_index  = idx;
	assign res.data_length = siglen_d;
	assign res.frames_good = good_d;

	`XCPD_ASSERT(a_good_counts, (step && ev == EV_GOOD) |=> (good_q == $past(good_q) + 32'd1), "good frame not counted")
	`XCPD_ASSERT(a_timeout_idle, (step && ev == EV_TIMEOUT) |=> (phase_q == PH_IDLE), "timeout did not return to idle")
	`XCPD_ASSERT(a_data_in_range, (step && ev == EV_DATA) |-> (bcnt_q < siglen_q), "data index beyond data length")

endmodule

FILE: hw/rtl/xcpd_outq.sv
// two-entry result buffer between the step logic and the output stream
// depends on xcpd_pkg and the assertion macro header
`include "xor_checked_packet_deframer_core_defines.svh"
module xcpd_outq
	import xcpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic full,
	output logic pop_valid,
	input  logic pop_ready,
	output res_t pop_res
);

	res_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = pop_valid && pop_ready;
	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_res   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`XCPD_ASSERT(a_cnt_range, cnt_q != 2'd3, "result buffer count out of range")
	`XCPD_ASSERT(a_no_overrun, push |-> (cnt_q != 2'd2), "push into a full result buffer")
	`XCPD_ASSERT(a_drain, (pop && !push && cnt_q == 2'd1) |=> (cnt_q == 2'd0), "buffer did not drain")

endmodule
